// ===== rtl/core/ale_pkg.sv =====
package ale_pkg;

    localparam int DEPTH    = 128;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = 8;
    localparam int KEY_W    = 32;
    localparam int NAME_W   = 64;
    localparam int GRP_SZ   = 8;
    localparam int GRP_W    = $clog2(GRP_SZ);
    localparam int N_GRP    = DEPTH / GRP_SZ;
    localparam int NGRP_W   = $clog2(N_GRP);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    typedef logic signed [KEY_W-1:0] t_key;
    typedef logic [NAME_W-1:0]       t_name;
    typedef logic [IDX_W-1:0]        t_idx;
    typedef logic [CNT_W-1:0]        t_cnt;

    typedef enum logic [1:0] {
        OP_INS  = 2'd0,
        OP_ORD  = 2'd1,
        OP_DEL  = 2'd2,
        OP_SRCH = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BADPOS   = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        SH_NONE = 2'd0,
        SH_UP   = 2'd1,
        SH_DOWN = 2'd2
    } t_shift;

    // broadcast from the controller to every cell
    typedef struct packed {
        t_shift shift;
        t_idx   pos;
        logic   ord;
        t_cnt   count;
        t_key   key;
        t_name  name;
    } t_cell_ctl;

endpackage

// ===== rtl/core/ale_if.sv =====
interface ale_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [7:0]  position;
    logic signed [31:0] key;
    logic [63:0] name_tag;

    modport source (output valid, output opcode, output position, output key,
                    output name_tag, input ready);
    modport sink   (input valid, input opcode, input position, input key,
                    input name_tag, output ready);
endinterface

interface ale_out_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic [1:0]  status;
    logic [7:0]  index;
    logic [7:0]  count;

    modport source (output valid, output ok, output status, output index,
                    output count, input ready);
    modport sink   (input valid, input ok, input status, input index,
                    input count, output ready);
endinterface

// ===== rtl/core/ale_cell.sv =====
module ale_cell (
    input  logic               i_clk,
    input  ale_pkg::t_cell_ctl i_ctl,
    input  ale_pkg::t_idx      i_idx,
    input  ale_pkg::t_key      i_key_left,
    input  ale_pkg::t_name     i_name_left,
    input  ale_pkg::t_key      i_key_right,
    input  ale_pkg::t_name     i_name_right,
    output ale_pkg::t_key      o_key,
    output ale_pkg::t_name     o_name,
    output logic               o_hit
);

    ale_pkg::t_key  r_key;
    ale_pkg::t_name r_name;
    logic           in_list;
    logic           match;

    always_ff @(posedge i_clk) begin
        case (i_ctl.shift)
            ale_pkg::SH_UP: begin
                if (i_idx > i_ctl.pos) begin
                    r_key  <= i_key_left;
                    r_name <= i_name_left;
                end else if (i_idx == i_ctl.pos) begin
                    r_key  <= i_ctl.key;
                    r_name <= i_ctl.name;
                end
            end
            ale_pkg::SH_DOWN: begin
                if (i_idx >= i_ctl.pos) begin
                    r_key  <= i_key_right;
                    r_name <= i_name_right;
                end
            end
            default: begin
            end
        endcase
    end

    // ordered insert looks for the first key not smaller than the new one
    assign in_list = {1'b0, i_idx} < i_ctl.count;
    assign match   = i_ctl.ord ? !(i_ctl.key > r_key) : (i_ctl.name == r_name);
    assign o_hit   = in_list && match;
    assign o_key   = r_key;
    assign o_name  = r_name;

endmodule

// ===== rtl/core/ale_find.sv =====
module ale_find (
    input  logic                        i_clk,
    input  logic [ale_pkg::DEPTH-1:0]   i_hit,
    output logic                        o_found,
    output ale_pkg::t_idx               o_idx
);

    logic [ale_pkg::DEPTH-1:0]      r_hit;
    logic [ale_pkg::N_GRP-1:0]      r_grp_any;
    logic [ale_pkg::GRP_W-1:0]      r_grp_idx [ale_pkg::N_GRP];
    logic [ale_pkg::N_GRP-1:0]      n_grp_any;
    logic [ale_pkg::GRP_W-1:0]      n_grp_idx [ale_pkg::N_GRP];
    logic                           r_found;
    ale_pkg::t_idx                  r_idx;
    logic                           n_found;
    ale_pkg::t_idx                  n_idx;

    // first stage: lowest hit inside each group of eight
    always_comb begin
        for (int g = 0; g < ale_pkg::N_GRP; g++) begin
            n_grp_any[g] = 1'b0;
            n_grp_idx[g] = '0;
            for (int b = ale_pkg::GRP_SZ - 1; b >= 0; b--) begin
                if (r_hit[g * ale_pkg::GRP_SZ + b]) begin
                    n_grp_any[g] = 1'b1;
                    n_grp_idx[g] = ale_pkg::GRP_W'(b);
                end
            end
        end
    end

    // second stage: lowest group with a hit
    always_comb begin
        n_found = 1'b0;
        n_idx   = '0;
        for (int g = ale_pkg::N_GRP - 1; g >= 0; g--) begin
            if (r_grp_any[g]) begin
                n_found = 1'b1;
                n_idx   = {ale_pkg::NGRP_W'(g), r_grp_idx[g]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit     <= i_hit;
        r_grp_any <= n_grp_any;
        r_grp_idx <= n_grp_idx;
        r_found   <= n_found;
        r_idx     <= n_idx;
    end

    assign o_found = r_found;
    assign o_idx   = r_idx;

endmodule

// ===== rtl/core/array_list_engine_top.sv =====
// Bounded list of up to 128 records (signed 32-bit key, 64-bit name tag) kept
// in a row of cells, one record per cell. Opcodes: insert at position,
// ordered insert (before the first key not smaller), remove at position and
// search by name tag. Every word yields exactly one result word with ok,
// status, index and the count after the operation. The result word is
// registered after these steps in order: all cells compare against the
// captured word at once, the first-hit encoder registers the hit row, then
// the lowest hit in each group of eight, then the lowest group with a hit,
// and last the whole row shifts up or down by one place in parallel while
// the result is registered. The next word is taken in the cycle after that;
// the shift waits for as long as a previous result still sits unread in the
// output register. One operation is in flight at a time; a finished result
// sits in an output register, and the next word is already accepted while
// that result waits. Cell contents reset to nothing in particular; only the
// fill count, the state and the output valid flag are cleared.
module array_list_engine_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ale_in_if.sink     i_in,
    ale_out_if.source  o_out
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_HIT  = 5'b00010,
        S_GRP  = 5'b00100,
        S_FIN  = 5'b01000,
        S_EXEC = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // captured command word
    ale_pkg::t_opcode r_op;
    logic [7:0]       r_pos;
    ale_pkg::t_key    r_key;
    ale_pkg::t_name   r_name;

    ale_pkg::t_cnt    r_count, n_count;

    // output register
    logic             r_out_valid;
    logic             r_ok, n_ok;
    ale_pkg::t_status r_status, n_status;
    logic [7:0]       r_index, n_index;
    logic [7:0]       r_out_count;

    // cell row
    ale_pkg::t_cell_ctl          cell_ctl;
    ale_pkg::t_key               cell_key  [ale_pkg::DEPTH];
    ale_pkg::t_name              cell_name [ale_pkg::DEPTH];
    logic [ale_pkg::DEPTH-1:0]   cell_hit;

    logic             find_found;
    ale_pkg::t_idx    find_idx;

    logic             advance;
    logic             full;
    ale_pkg::t_shift  exec_shift;
    ale_pkg::t_idx    exec_pos;

    assign i_in.ready = (r_state == S_IDLE);
    assign full       = (r_count == ale_pkg::FULL_COUNT);
    // the result register must be free before the row is touched
    assign advance    = (r_state == S_EXEC) && (!r_out_valid || o_out.ready);

    // decide the operation from the encoder result
    always_comb begin
        n_ok       = 1'b0;
        n_status   = ale_pkg::ST_OK;
        n_index    = '0;
        n_count    = r_count;
        exec_shift = ale_pkg::SH_NONE;
        exec_pos   = r_pos[ale_pkg::IDX_W-1:0];
        case (r_op)
            ale_pkg::OP_INS: begin
                if (full) begin
                    n_status = ale_pkg::ST_FULL;
                end else if (r_pos > r_count) begin
                    n_status = ale_pkg::ST_BADPOS;
                end else begin
                    n_ok       = 1'b1;
                    n_index    = r_pos;
                    n_count    = r_count + 1'b1;
                    exec_shift = ale_pkg::SH_UP;
                end
            end
            ale_pkg::OP_ORD: begin
                if (full) begin
                    n_status = ale_pkg::ST_FULL;
                end else begin
                    // no larger-or-equal key: append at the end
                    exec_pos   = find_found ? find_idx : r_count[ale_pkg::IDX_W-1:0];
                    n_ok       = 1'b1;
                    n_index    = 8'(exec_pos);
                    n_count    = r_count + 1'b1;
                    exec_shift = ale_pkg::SH_UP;
                end
            end
            ale_pkg::OP_DEL: begin
                if (r_pos >= r_count) begin
                    n_status = ale_pkg::ST_BADPOS;
                end else begin
                    n_ok       = 1'b1;
                    n_index    = r_pos;
                    n_count    = r_count - 1'b1;
                    exec_shift = ale_pkg::SH_DOWN;
                end
            end
            ale_pkg::OP_SRCH: begin
                if (find_found) begin
                    n_ok    = 1'b1;
                    n_index = 8'(find_idx);
                end else begin
                    n_status = ale_pkg::ST_NOTFOUND;
                    n_index  = r_count;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        cell_ctl.shift = advance ? exec_shift : ale_pkg::SH_NONE;
        cell_ctl.pos   = exec_pos;
        cell_ctl.ord   = (r_op == ale_pkg::OP_ORD);
        cell_ctl.count = r_count;
        cell_ctl.key   = r_key;
        cell_ctl.name  = r_name;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in.valid) n_state = S_HIT;
            S_HIT:   n_state = S_GRP;
            S_GRP:   n_state = S_FIN;
            S_FIN:   n_state = S_EXEC;
            S_EXEC:  if (advance) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (advance) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_op   <= ale_pkg::t_opcode'(i_in.opcode);
            r_pos  <= i_in.position;
            r_key  <= i_in.key;
            r_name <= i_in.name_tag;
        end
        if (advance) begin
            r_ok        <= n_ok;
            r_status    <= n_status;
            r_index     <= n_index;
            r_out_count <= n_count;
        end
    end

    // the row: each cell sees its left and right neighbor
    for (genvar c = 0; c < ale_pkg::DEPTH; c++) begin : g_cell
        ale_pkg::t_key  key_left, key_right;
        ale_pkg::t_name name_left, name_right;

        if (c == 0) begin : g_first
            assign key_left  = '0;
            assign name_left = '0;
        end else begin : g_inner_l
            assign key_left  = cell_key[c-1];
            assign name_left = cell_name[c-1];
        end

        if (c == ale_pkg::DEPTH - 1) begin : g_last
            assign key_right  = '0;
            assign name_right = '0;
        end else begin : g_inner_r
            assign key_right  = cell_key[c+1];
            assign name_right = cell_name[c+1];
        end

        ale_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (cell_ctl),
            .i_idx        (ale_pkg::IDX_W'(c)),
            .i_key_left   (key_left),
            .i_name_left  (name_left),
            .i_key_right  (key_right),
            .i_name_right (name_right),
            .o_key        (cell_key[c]),
            .o_name       (cell_name[c]),
            .o_hit        (cell_hit[c])
        );
    end

    ale_find u_find (
        .i_clk   (i_clk),
        .i_hit   (cell_hit),
        .o_found (find_found),
        .o_idx   (find_idx)
    );

    assign o_out.valid  = r_out_valid;
    assign o_out.ok     = r_ok;
    assign o_out.status = r_status;
    assign o_out.index  = r_index;
    assign o_out.count  = r_out_count;

endmodule

// ===== tb/tb_array_list_engine_top.sv =====
`timescale 1ns / 100ps

module tb_array_list_engine_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct packed {
        logic             ok;
        ale_pkg::t_status status;
        logic [7:0]       index;
        logic [7:0]       count;
    } t_list_result;

    logic clk;
    logic rst_n;

    ale_in_if  in_if ();
    ale_out_if out_if ();

    array_list_engine_top u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // shadow copy of the list
    ale_pkg::t_key  list_keys  [ale_pkg::DEPTH];
    ale_pkg::t_name list_names [ale_pkg::DEPTH];
    int             list_count;

    t_list_result pending_results [$];
    int           error_count;

    int src_idle_pct;
    int snk_stall_pct;
    bit hold_req;
    int hold_left;
    int quiet_cycles;

    ale_pkg::t_key  key_pool  [7] = '{32'sh8000_0000, 32'sh7fff_ffff, -1, 0, 1, 2, -2};
    ale_pkg::t_name name_pool [8];

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // shadow list update; returns the result word the block must produce
    function automatic t_list_result apply_list_op(ale_pkg::t_opcode op, logic [7:0] pos,
                                                   ale_pkg::t_key key, ale_pkg::t_name name);
        t_list_result res;
        int slot;
        res = '{ok: 1'b0, status: ale_pkg::ST_OK, index: '0, count: '0};
        case (op)
            ale_pkg::OP_INS, ale_pkg::OP_ORD: begin
                if (op == ale_pkg::OP_ORD) begin
                    // first entry whose key is not smaller
                    slot = 0;
                    while (slot < list_count && key > list_keys[slot])
                        slot++;
                end else begin
                    slot = int'(pos);
                end
                // fullness wins over a bad position
                if (list_count >= ale_pkg::DEPTH) begin
                    res.status = ale_pkg::ST_FULL;
                end else if (slot > list_count) begin
                    res.status = ale_pkg::ST_BADPOS;
                end else begin
                    for (int q = list_count; q > slot; q--) begin
                        list_keys[q]  = list_keys[q-1];
                        list_names[q] = list_names[q-1];
                    end
                    list_keys[slot]  = key;
                    list_names[slot] = name;
                    list_count++;
                    res.ok    = 1'b1;
                    res.index = 8'(slot);
                end
            end
            ale_pkg::OP_DEL: begin
                if (int'(pos) >= list_count) begin
                    res.status = ale_pkg::ST_BADPOS;
                end else begin
                    for (int q = int'(pos) + 1; q < list_count; q++) begin
                        list_keys[q-1]  = list_keys[q];
                        list_names[q-1] = list_names[q];
                    end
                    list_count--;
                    res.ok    = 1'b1;
                    res.index = pos;
                end
            end
            default: begin
                slot = 0;
                while (slot < list_count && list_names[slot] != name)
                    slot++;
                if (slot < list_count) begin
                    res.ok    = 1'b1;
                    res.index = 8'(slot);
                end else begin
                    res.status = ale_pkg::ST_NOTFOUND;
                    res.index  = 8'(list_count);
                end
            end
        endcase
        res.count = 8'(list_count);
        return res;
    endfunction

    // offer one word at the falling edge, hold it until taken
    task automatic send_word(input ale_pkg::t_opcode op, input logic [7:0] pos,
                             input ale_pkg::t_key key, input ale_pkg::t_name name);
        while ($urandom_range(99) < src_idle_pct)
            @(negedge clk);
        in_if.valid    = 1'b1;
        in_if.opcode   = op;
        in_if.position = pos;
        in_if.key      = key;
        in_if.name_tag = name;
        do
            @(posedge clk);
        while (!in_if.ready);
        pending_results.push_back(apply_list_op(op, pos, key, name));
        @(negedge clk);
        in_if.valid = 1'b0;
    endtask

    // random word, mix of operations given in percent; search is the rest
    task automatic send_random(input int ins_pct, input int del_pct);
        int unsigned      roll;
        ale_pkg::t_opcode op;
        logic [7:0]       pos;
        ale_pkg::t_key    key;
        ale_pkg::t_name   name;
        roll = $urandom_range(99);
        if (roll < ins_pct)
            op = ($urandom_range(1) == 0) ? ale_pkg::OP_INS : ale_pkg::OP_ORD;
        else if (roll < ins_pct + del_pct)
            op = ale_pkg::OP_DEL;
        else
            op = ale_pkg::OP_SRCH;

        // mostly legal positions, some anywhere in the field
        if ($urandom_range(4) == 0)
            pos = 8'($urandom_range(255));
        else if (op == ale_pkg::OP_DEL)
            pos = (list_count == 0) ? 8'd0 : 8'($urandom_range(list_count - 1));
        else
            pos = 8'($urandom_range(list_count));

        case ($urandom_range(4))
            0: key = key_pool[$urandom_range(6)];
            1: key = (list_count != 0) ? list_keys[$urandom_range(list_count - 1)]
                                       : ale_pkg::t_key'($urandom);
            default: key = ale_pkg::t_key'($urandom);
        endcase

        // small name pool gives duplicates, searches mostly hit live entries
        roll = $urandom_range(9);
        if (op == ale_pkg::OP_SRCH && list_count != 0 && roll < 5)
            name = list_names[$urandom_range(list_count - 1)];
        else if (roll < 7)
            name = name_pool[$urandom_range(7)];
        else
            name = {$urandom, $urandom};

        send_word(op, pos, key, name);
    endtask

    task automatic wait_for_results();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic test_empty_list();
        send_word(ale_pkg::OP_DEL,  8'd0,   0, '0);
        send_word(ale_pkg::OP_SRCH, 8'd0,   0, '0);
        send_word(ale_pkg::OP_INS,  8'd1,   7, 64'h1);
        send_word(ale_pkg::OP_INS,  8'd255, 7, 64'h1);
        send_word(ale_pkg::OP_DEL,  8'd255, 0, '0);
    endtask

    task automatic test_positional();
        send_word(ale_pkg::OP_INS, 8'd0, 32'sh7fff_ffff, '1);
        send_word(ale_pkg::OP_INS, 8'd1, -1, '0);                       // append
        send_word(ale_pkg::OP_INS, 8'd1, 5, 64'h0123_4567_89ab_cdef);   // middle
        send_word(ale_pkg::OP_INS, 8'd4, 9, 64'h2);                     // past the count
        send_word(ale_pkg::OP_DEL, 8'd3, 0, '0);                        // at the count
        send_word(ale_pkg::OP_DEL, 8'd1, 0, '0);
    endtask

    task automatic test_ordered();
        send_word(ale_pkg::OP_ORD, 8'd0,   32'sh8000_0000, 64'h1);
        send_word(ale_pkg::OP_ORD, 8'd200, 0, 64'h2);
        send_word(ale_pkg::OP_ORD, 8'd0,   32'sh7fff_ffff, '1);         // equal key, same name
        send_word(ale_pkg::OP_ORD, 8'd0,   -1, 64'hfedc_ba98_7654_3210);
    endtask

    task automatic test_search_and_remove();
        send_word(ale_pkg::OP_SRCH, 8'd0, 0, '1);                       // duplicate, first hit
        send_word(ale_pkg::OP_SRCH, 8'd0, 0, '0);
        send_word(ale_pkg::OP_SRCH, 8'd0, 0, 64'hdead_beef_cafe_f00d);  // miss
        send_word(ale_pkg::OP_DEL,  8'(list_count - 1), 0, '0);         // last entry
        send_word(ale_pkg::OP_DEL,  8'd0, 0, '0);
        send_word(ale_pkg::OP_DEL,  8'd128, 0, '0);
    endtask

    // fill to the top, hammer the full list, drain to empty, then mixed traffic
    task automatic test_fill_and_drain(input int src_pct, input int snk_pct);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        while (list_count < ale_pkg::DEPTH)
            send_random(85, 5);
        repeat (20) send_random(60, 15);
        while (list_count > 0)
            send_random(5, 85);
        repeat (30) send_random(40, 30);
    endtask

    // receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_backpressure();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_req      = 1'b1;
        repeat (40) send_random(50, 20);
    endtask

    // receiver: random stalls, or a long hold-off when requested
    always @(negedge clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            out_if.ready = 1'b0;
            hold_left--;
        end else begin
            out_if.ready = ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // result check against the oldest expectation
    always @(posedge clk) begin
        t_list_result want;
        if (rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected: ok %0d status %0d index %0d %s %0d",
                       out_if.ok, out_if.status, out_if.index, "count", out_if.count);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (out_if.ok !== want.ok) begin
                    $error("ok: expected %0d, got %0d", want.ok, out_if.ok);
                    error_count++;
                end
                if (out_if.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, out_if.status);
                    error_count++;
                end
                if (out_if.index !== want.index) begin
                    $error("index: expected %0d, got %0d", want.index, out_if.index);
                    error_count++;
                end
                if (out_if.count !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, out_if.count);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        in_if.valid    = 1'b0;
        in_if.opcode   = ale_pkg::OP_INS;
        in_if.position = '0;
        in_if.key      = '0;
        in_if.name_tag = '0;
        out_if.ready   = 1'b0;
        rst_n          = 1'b0;
        list_count     = 0;
        error_count    = 0;
        src_idle_pct   = 0;
        snk_stall_pct  = 0;
        hold_req       = 1'b0;
        hold_left      = 0;
        quiet_cycles   = 0;

        name_pool[0] = '0;
        name_pool[1] = '1;
        for (int n = 2; n < 8; n++)
            name_pool[n] = {$urandom, $urandom};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_list();
        test_positional();
        test_ordered();
        test_search_and_remove();
        test_fill_and_drain(0, 0);
        test_fill_and_drain(75, 0);
        test_fill_and_drain(0, 75);
        test_fill_and_drain(33, 33);
        test_backpressure();
        wait_for_results();

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
